// ===== hw/rtl/ehw_pkg.sv =====
// Shared types and codes for the EBML element header walker.
// Used by ehw_walker and by the ebml_element_header_walker_core top level.
`timescale 1ns / 1ps

package ehw_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_HEADER    = 2'd0;
  localparam logic [1:0] STATUS_MALFORMED = 2'd1;
  localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

  // One result beat.
  typedef struct packed {
    logic [31:0] element_id;
    logic [2:0]  id_length;
    logic [31:0] data_offset;
    logic [31:0] element_size;
    logic        size_was_unknown;
    logic [1:0]  status;
  } ehw_result_t;

endpackage

// ===== hw/rtl/ehw_walker.sv =====
// Walk state and the per-byte header parsing step of the EBML header walker.
// Depends on ehw_pkg for the result type and status codes.
`timescale 1ns / 1ps

module ehw_walker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                region_start_i,
  input  logic [31:0]         region_length_i,
  input  logic [31:0]         region_base_i,
  output logic                emit_o,
  output ehw_pkg::ehw_result_t result_o
);

  // Parse phases.
  localparam logic [2:0] PH_ID_FIRST = 3'd0;
  localparam logic [2:0] PH_ID_REST  = 3'd1;
  localparam logic [2:0] PH_SZ_FIRST = 3'd2;
  localparam logic [2:0] PH_SZ_REST  = 3'd3;
  localparam logic [2:0] PH_SKIP     = 3'd4;

  // Raw 8-byte size vint that means an unknown size.
  localparam logic [56:0] UNKNOWN_RAW = 57'h1FF_FFFF_FFFF_FFFF;

  // Total vint length given by the leading one of the first byte.
  function automatic logic [3:0] marker_length(input logic [7:0] first);
    logic [3:0] len;
    len = 4'd9;
    for (int i = 0; i < 8; i++) begin
      if (first[i]) begin
        len = 4'(8 - i);
      end
    end
    return len;
  endfunction

  // Data bits of a size vint of the given length.
  function automatic logic [56:0] vint_mask(input logic [3:0] len);
    logic [56:0] m;
    case (len)
      4'd1:    m = 57'h7F;
      4'd2:    m = 57'h3FFF;
      4'd3:    m = 57'h1F_FFFF;
      4'd4:    m = 57'hFFF_FFFF;
      4'd5:    m = 57'h7_FFFF_FFFF;
      4'd6:    m = 57'h3FF_FFFF_FFFF;
      4'd7:    m = 57'h1_FFFF_FFFF_FFFF;
      4'd8:    m = 57'hFF_FFFF_FFFF_FFFF;
      default: m = '0;
    endcase
    return m;
  endfunction

  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic [31:0] id_acc_q, id_acc_d;
  logic [2:0]  id_exp_q, id_exp_d;
  logic [2:0]  id_seen_q, id_seen_d;
  logic [56:0] size_acc_q, size_acc_d;
  logic [3:0]  size_exp_q, size_exp_d;
  logic [3:0]  size_seen_q, size_seen_d;
  logic [31:0] skip_q, skip_d;
  logic        stopped_q, stopped_d;

  // Walk state as seen by this byte, after a region start clears it.
  logic [31:0] cur_pos;
  logic [2:0]  cur_phase;
  logic        cur_stopped;

  assign cur_pos     = region_start_i ? '0 : pos_q;
  assign cur_phase   = region_start_i ? PH_ID_FIRST : phase_q;
  assign cur_stopped = region_start_i ? 1'b0 : stopped_q;

  logic [31:0] pos_next;
  logic        last_byte;
  logic [31:0] remaining;
  logic [3:0]  mlen;
  logic [2:0]  id_seen_inc;
  logic [3:0]  size_seen_inc;
  logic [56:0] size_shifted;
  logic [56:0] hdr_acc;
  logic [3:0]  hdr_len;
  logic [56:0] hdr_value;
  logic        hdr_unknown;
  logic [31:0] hdr_size;
  logic        do_header;
  logic        do_trunc_check;
  logic        do_error;
  logic [1:0]  err_code;
  logic        emit;

  assign pos_next      = cur_pos + 32'd1;
  assign last_byte     = (pos_next >= region_length_i);
  assign remaining     = region_length_i - pos_next;
  assign mlen          = marker_length(data_byte_i);
  assign id_seen_inc   = id_seen_q + 3'd1;
  assign size_seen_inc = size_seen_q + 4'd1;
  assign size_shifted  = {size_acc_q[48:0], data_byte_i};

  // One step of the walk for the byte at the current position.
  always_comb begin
    pos_d          = cur_pos;
    phase_d        = cur_phase;
    id_acc_d       = id_acc_q;
    id_exp_d       = id_exp_q;
    id_seen_d      = id_seen_q;
    size_acc_d     = size_acc_q;
    size_exp_d     = size_exp_q;
    size_seen_d    = size_seen_q;
    skip_d         = skip_q;
    stopped_d      = cur_stopped;
    do_header      = 1'b0;
    do_trunc_check = 1'b0;
    do_error       = 1'b0;
    err_code       = ehw_pkg::STATUS_MALFORMED;

    if (!cur_stopped) begin
      if (cur_pos >= region_length_i) begin
        stopped_d = 1'b1;
      end else begin
        case (cur_phase)
          PH_ID_FIRST: begin
            if (last_byte) begin
              // Fewer than two bytes left: stop without a result.
              stopped_d = 1'b1;
            end else if (data_byte_i == 8'd0 || mlen > 4'd4) begin
              do_error = 1'b1;
            end else begin
              id_acc_d       = {24'd0, data_byte_i};
              id_exp_d       = mlen[2:0];
              id_seen_d      = 3'd1;
              phase_d        = (mlen == 4'd1) ? PH_SZ_FIRST : PH_ID_REST;
              do_trunc_check = 1'b1;
            end
          end
          PH_ID_REST: begin
            id_acc_d       = {id_acc_q[23:0], data_byte_i};
            id_seen_d      = id_seen_inc;
            do_trunc_check = 1'b1;
            if (id_seen_inc >= id_exp_q) begin
              phase_d = PH_SZ_FIRST;
            end
          end
          PH_SZ_FIRST: begin
            if (data_byte_i == 8'd0) begin
              do_error = 1'b1;
            end else begin
              size_acc_d  = {49'd0, data_byte_i};
              size_exp_d  = mlen;
              size_seen_d = 4'd1;
              if (mlen == 4'd1) begin
                do_header = 1'b1;
              end else begin
                phase_d        = PH_SZ_REST;
                do_trunc_check = 1'b1;
              end
            end
          end
          PH_SZ_REST: begin
            size_acc_d  = size_shifted;
            size_seen_d = size_seen_inc;
            if (size_seen_inc >= size_exp_q) begin
              do_header = 1'b1;
            end else begin
              do_trunc_check = 1'b1;
            end
          end
          PH_SKIP: begin
            if (skip_q != 32'd0) begin
              skip_d = skip_q - 32'd1;
            end
            if (skip_q <= 32'd1) begin
              phase_d = PH_ID_FIRST;
            end
            pos_d = pos_next;
          end
          default: begin
            phase_d   = PH_ID_FIRST;
            stopped_d = 1'b1;
          end
        endcase

        // An incomplete header needs one more region byte.
        if (do_trunc_check) begin
          if (last_byte) begin
            do_error = 1'b1;
            err_code = ehw_pkg::STATUS_TRUNCATED;
          end else begin
            pos_d = pos_next;
          end
        end
      end
    end

    if (do_error) begin
      stopped_d = 1'b1;
    end
    if (do_header) begin
      skip_d  = hdr_size;
      phase_d = (hdr_size != 32'd0) ? PH_SKIP : PH_ID_FIRST;
      pos_d   = pos_next;
    end
  end

  // Size decode: unknown-size substitution and clamping to the region.
  // A header completes only in the two size phases, so the size vint is
  // either this byte alone or the held bytes with this one shifted in.
  assign hdr_acc     = (cur_phase == PH_SZ_FIRST) ? {49'd0, data_byte_i} : size_shifted;
  assign hdr_len     = (cur_phase == PH_SZ_FIRST) ? mlen : size_exp_q;
  assign hdr_value   = hdr_acc & vint_mask(hdr_len);
  assign hdr_unknown = (hdr_len == 4'd8) && (hdr_acc == UNKNOWN_RAW);
  always_comb begin
    if (hdr_unknown || hdr_value[56:32] != 25'd0 || hdr_value[31:0] > remaining) begin
      hdr_size = remaining;
    end else begin
      hdr_size = hdr_value[31:0];
    end
  end

  // Result beat; error results carry only the status.
  assign emit = do_header || do_error;
  always_comb begin
    result_o = '0;
    if (do_error) begin
      result_o.status = err_code;
    end else begin
      result_o.element_id       = id_acc_q;
      result_o.id_length        = id_exp_q;
      result_o.data_offset      = region_base_i + pos_next;
      result_o.element_size     = hdr_size;
      result_o.size_was_unknown = hdr_unknown;
      result_o.status           = ehw_pkg::STATUS_HEADER;
    end
  end
  assign emit_o = emit;

  // Walk state registers, updated once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= PH_ID_FIRST;
      id_acc_q    <= '0;
      id_exp_q    <= '0;
      id_seen_q   <= '0;
      size_acc_q  <= '0;
      size_exp_q  <= '0;
      size_seen_q <= '0;
      skip_q      <= '0;
      stopped_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      phase_q     <= phase_d;
      id_acc_q    <= id_acc_d;
      id_exp_q    <= id_exp_d;
      id_seen_q   <= id_seen_d;
      size_acc_q  <= size_acc_d;
      size_exp_q  <= size_exp_d;
      size_seen_q <= size_seen_d;
      skip_q      <= skip_d;
      stopped_q   <= stopped_d;
    end
  end

`ifndef SYNTH
  // A stopped walk stays silent until the next region start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q && !region_start_i |-> !emit_o)
    else $error("walker emitted a result after the walk stopped");

  // A reported size never reaches past the end of the region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && result_o.status == ehw_pkg::STATUS_HEADER |->
      result_o.element_size <= remaining)
    else $error("element size exceeds the bytes left in the region");

  // Every error result stops the walk.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && emit_o && result_o.status != ehw_pkg::STATUS_HEADER |=> stopped_q)
    else $error("walk continued after an error result");
`endif

endmodule

// ===== hw/rtl/ebml_element_header_walker_core.sv =====
// EBML element header walker: a byte stream in, one beat per element header out.
// Top level; instantiates ehw_walker and uses ehw_pkg.
`timescale 1ns / 1ps

// The block takes one byte of an EBML master region per input beat and walks
// the region's direct children, emitting one result beat per child header
// (raw ID, ID length, absolute payload offset, clamped payload size) and
// skipping each payload. A malformed or cut-off header gives one error beat
// and stops the walk until a beat with region_start set. Set region_length
// and region_base through the write port while the block is idle. Throughput
// is one byte per clock cycle: each byte passes an input register, one step
// of the walk logic and, if it completes a header, a result register that
// offers the result beat. Input stalls only when a byte that produces a
// result meets a result register that still holds an untaken beat.
module ebml_element_header_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  // Byte input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        region_start_i,
  // Result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] element_id_o,
  output logic [2:0]  id_length_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] element_size_o,
  output logic        size_was_unknown_o,
  output logic [1:0]  status_o
);

  // Register indexes on the configuration port.
  localparam logic CFG_REGION_LENGTH = 1'b0;
  localparam logic CFG_REGION_BASE   = 1'b1;

  logic [31:0] region_length_q;
  logic [31:0] region_base_q;

  logic        in_valid_q;
  logic [7:0]  data_q;
  logic        start_q;

  logic        out_valid_q;
  ehw_pkg::ehw_result_t out_res_q;

  logic        emit;
  ehw_pkg::ehw_result_t step_res;
  logic        advance;
  logic        in_accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_length_q <= '0;
      region_base_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REGION_LENGTH: region_length_q <= cfg_wdata_i;
        CFG_REGION_BASE:   region_base_q   <= cfg_wdata_i;
        default:           region_length_q <= region_length_q;
      endcase
    end
  end

  // The held byte moves on unless it makes a result and the result
  // register is still occupied.
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q  <= data_byte_i;
      start_q <= region_start_i;
    end
  end

  ehw_walker u_walker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (advance),
    .data_byte_i    (data_q),
    .region_start_i (start_q),
    .region_length_i(region_length_q),
    .region_base_i  (region_base_q),
    .emit_o         (emit),
    .result_o       (step_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign element_id_o       = out_res_q.element_id;
  assign id_length_o        = out_res_q.id_length;
  assign data_offset_o      = out_res_q.data_offset;
  assign element_size_o     = out_res_q.element_size;
  assign size_was_unknown_o = out_res_q.size_was_unknown;
  assign status_o           = out_res_q.status;

`ifndef SYNTH
  // A waiting result beat is never overwritten by a new one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance && emit))
    else $error("result register overwritten while its beat was waiting");

  // Error beats carry nothing but their status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ehw_pkg::STATUS_HEADER |->
      element_id_o == 32'd0 && id_length_o == 3'd0 && element_size_o == 32'd0)
    else $error("error result carries nonzero fields");

  // A header beat has an ID of one to four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ehw_pkg::STATUS_HEADER |->
      id_length_o >= 3'd1 && id_length_o <= 3'd4)
    else $error("header result with an invalid ID length");
`endif

endmodule

// ===== tb/ebml_element_header_walker_core_test.sv =====
// Self-checking testbench for ebml_element_header_walker_core.
// Drives byte beats from a queue, predicts each result beat in-line and checks the
// result beats; depends on ehw_pkg and the walker RTL only.
`timescale 1ns / 1ps

module ebml_element_header_walker_core_test;

  // Register indexes of the configuration port.
  localparam logic REG_REGION_LENGTH = 1'b0;
  localparam logic REG_REGION_BASE   = 1'b1;

  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_PRINTED   = 40;

  localparam logic [56:0] UNKNOWN_SIZE_RAW = '1;
  localparam logic [63:0] UNKNOWN_SIZE_VINT = 64'h01FF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    WALK_ID_FIRST,
    WALK_ID_REST,
    WALK_SIZE_FIRST,
    WALK_SIZE_REST,
    WALK_SKIP
  } walk_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } byte_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_REGION_LENGTH;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        region_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] element_id_o;
  logic [2:0]  id_length_o;
  logic [31:0] data_offset_o;
  logic [31:0] element_size_o;
  logic        size_was_unknown_o;
  logic [1:0]  status_o;

  ebml_element_header_walker_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .region_start_i     (region_start_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .element_id_o       (element_id_o),
    .id_length_o        (id_length_o),
    .data_offset_o      (data_offset_o),
    .element_size_o     (element_size_o),
    .size_was_unknown_o (size_was_unknown_o),
    .status_o           (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stimulus and scoreboard storage.
  byte_beat_t           pending_bytes[$];
  ehw_pkg::ehw_result_t expected_headers[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  logic        next_start = 1'b0;
  logic        hold_wanted = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_cycles = 0;

  // Predictor copy of the registers and of the walk state.
  logic [31:0] region_len_cfg = '0;
  logic [31:0] region_base_cfg = '0;
  logic [31:0] w_pos = '0;
  walk_phase_e w_phase = WALK_ID_FIRST;
  logic [31:0] w_id = '0;
  logic [2:0]  w_id_exp = '0;
  logic [2:0]  w_id_seen = '0;
  logic [56:0] w_size = '0;
  logic [3:0]  w_size_exp = '0;
  logic [3:0]  w_size_seen = '0;
  logic [31:0] w_skip = '0;
  logic        w_stopped = 1'b0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Total vint length from the leading one bit; a zero byte gives 9.
  function automatic logic [3:0] vint_len(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 8; i++) if (b[i]) n = 4'(8 - i);
    return n;
  endfunction

  function automatic bit flag_error(output ehw_pkg::ehw_result_t r, input logic [1:0] code);
    r = '0;
    r.status = code;
    w_stopped = 1'b1;
    return 1'b1;
  endfunction

  // Last header byte seen: size substitution, clamping and the skip setup.
  function automatic bit header_result(output ehw_pkg::ehw_result_t r,
                                       input logic [31:0] p);
    logic [63:0] value;
    logic [31:0] left;
    logic        unknown;
    value   = {7'd0, w_size} & ((64'd1 << (7 * w_size_exp)) - 64'd1);
    left    = region_len_cfg - (p + 32'd1);
    unknown = (w_size_exp == 4'd8) && (w_size == UNKNOWN_SIZE_RAW);
    r = '0;
    r.element_id       = w_id;
    r.id_length        = w_id_exp;
    r.data_offset      = region_base_cfg + p + 32'd1;
    r.element_size     = (unknown || value > {32'd0, left}) ? left : value[31:0];
    r.size_was_unknown = unknown;
    r.status           = ehw_pkg::STATUS_HEADER;
    w_skip  = r.element_size;
    w_phase = (w_skip != 0) ? WALK_SKIP : WALK_ID_FIRST;
    w_pos   = p + 32'd1;
    return 1'b1;
  endfunction

  // Advances the walk by one byte; returns 1 when that byte yields a result.
  function automatic bit walk_byte(input logic [7:0] b, input logic start,
                                   output ehw_pkg::ehw_result_t r);
    logic [31:0] p;
    logic [3:0]  n;
    r = '0;
    if (start) begin
      w_pos = '0;
      w_phase = WALK_ID_FIRST;
      w_id = '0;
      w_id_exp = '0;
      w_id_seen = '0;
      w_size = '0;
      w_size_exp = '0;
      w_size_seen = '0;
      w_skip = '0;
      w_stopped = 1'b0;
    end
    if (w_stopped) return 1'b0;
    p = w_pos;
    if (p >= region_len_cfg) begin
      w_stopped = 1'b1;
      return 1'b0;
    end
    case (w_phase)
      WALK_ID_FIRST: begin
        // Fewer than two bytes left for a new element: stop without a result.
        if (region_len_cfg - p < 32'd2) begin
          w_stopped = 1'b1;
          return 1'b0;
        end
        n = vint_len(b);
        // A zero byte or a marker beyond four bytes is malformed.
        if (n > 4'd4) return flag_error(r, ehw_pkg::STATUS_MALFORMED);
        w_id      = {24'd0, b};
        w_id_exp  = n[2:0];
        w_id_seen = 3'd1;
        w_phase   = (n == 4'd1) ? WALK_SIZE_FIRST : WALK_ID_REST;
      end
      WALK_ID_REST: begin
        w_id = {w_id[23:0], b};
        w_id_seen++;
        if (w_id_seen >= w_id_exp) w_phase = WALK_SIZE_FIRST;
      end
      WALK_SIZE_FIRST: begin
        n = vint_len(b);
        if (n > 4'd8) return flag_error(r, ehw_pkg::STATUS_MALFORMED);
        w_size      = {49'd0, b};
        w_size_exp  = n;
        w_size_seen = 4'd1;
        if (n == 4'd1) return header_result(r, p);
        w_phase = WALK_SIZE_REST;
      end
      WALK_SIZE_REST: begin
        w_size = {w_size[48:0], b};
        w_size_seen++;
        if (w_size_seen >= w_size_exp) return header_result(r, p);
      end
      WALK_SKIP: begin
        if (w_skip != 0) w_skip--;
        if (w_skip == 0) w_phase = WALK_ID_FIRST;
        w_pos = p + 32'd1;
        return 1'b0;
      end
      default: begin
        w_phase = WALK_ID_FIRST;
        w_stopped = 1'b1;
        return 1'b0;
      end
    endcase
    // The header is still open, so the region has to hold one more byte.
    if (p + 32'd1 >= region_len_cfg) return flag_error(r, ehw_pkg::STATUS_TRUNCATED);
    w_pos = p + 32'd1;
    return 1'b0;
  endfunction

  // Sender: takes a beat off the queue, predicts on each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin : byte_driver
    ehw_pkg::ehw_result_t hdr;
    byte_beat_t           beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= '0;
      region_start_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        if (walk_byte(data_byte_i, region_start_i, hdr))
          expected_headers.insert(expected_headers.size(), hdr);
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          beat = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= beat.data;
          region_start_i <= beat.start;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here once requested.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_wanted != hold_taken) begin
      hold_cycles <= LONG_HOLD;
      hold_taken <= hold_wanted;
    end
  end

  // Receiver ready with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (hold_cycles == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Result monitor: every accepted beat against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    ehw_pkg::ehw_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_headers.size() == 0) begin
        report_mismatch($sformatf("result beat with none expected, status %0d", status_o));
      end else begin
        want = expected_headers.pop_front();
        if (element_id_o !== want.element_id)
          report_mismatch($sformatf("element_id %h, expected %h",
                                    element_id_o, want.element_id));
        if (id_length_o !== want.id_length)
          report_mismatch($sformatf("id_length %0d, expected %0d",
                                    id_length_o, want.id_length));
        if (data_offset_o !== want.data_offset)
          report_mismatch($sformatf("data_offset %h, expected %h",
                                    data_offset_o, want.data_offset));
        if (element_size_o !== want.element_size)
          report_mismatch($sformatf("element_size %h, expected %h",
                                    element_size_o, want.element_size));
        if (size_was_unknown_o !== want.size_was_unknown)
          report_mismatch($sformatf("size_was_unknown %b, expected %b",
                                    size_was_unknown_o, want.size_was_unknown));
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), '{data: b, start: next_start});
    next_start = 1'b0;
    bytes_queued++;
  endtask

  // Pushes the low n bytes of the vector, most significant first.
  task automatic push_bytes(input logic start, input int n, input logic [95:0] bytes);
    next_start = start;
    for (int k = n - 1; k >= 0; k--) push_byte(bytes[8 * k +: 8]);
  endtask

  // Waits until every queued beat is taken and every result has come back.
  task automatic wait_drained();
    @(posedge clk_i);
    while (bytes_taken != bytes_queued || expected_headers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regions(input logic [31:0] len, input logic [31:0] base);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_REGION_LENGTH;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_idx_i <= REG_REGION_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    region_len_cfg = len;
    region_base_cfg = base;
  endtask

  // One well-formed element header; returns its length and the payload wanted.
  task automatic add_element(output int hdr_bytes, output int payload);
    int          id_len;
    int          sz_len;
    logic        unknown;
    logic [7:0]  marker;
    logic [63:0] value;
    logic [63:0] vint;
    id_len = $urandom_range(1, 4);
    marker = 8'h80 >> (id_len - 1);
    push_byte(marker | (8'($urandom) & (marker - 8'd1)));
    repeat (id_len - 1) push_byte(8'($urandom));
    unknown = 1'b0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8: sz_len = 1;
      19: begin
        sz_len = 8;
        unknown = 1'b1;
      end
      default: sz_len = $urandom_range(2, 8);
    endcase
    if ($urandom_range(0, 9) < 7) value = 64'($urandom_range(0, 6));
    else value = {$urandom, $urandom};
    value &= (64'd1 << (7 * sz_len)) - 64'd1;
    vint = unknown ? UNKNOWN_SIZE_VINT : ((64'd1 << (7 * sz_len)) | value);
    for (int k = sz_len - 1; k >= 0; k--) push_byte(vint[8 * k +: 8]);
    hdr_bytes = id_len + sz_len;
    payload = (unknown || value > 64'd4096) ? 4096 : int'(value);
  endtask

  // One region of mostly well-formed elements, sometimes cut short or broken.
  task automatic add_region(input logic [31:0] len);
    int tgt;
    int pos;
    int hdr_bytes;
    int payload;
    tgt = (len > 32'd300) ? $urandom_range(40, 120) : int'(len);
    if (tgt > 1 && $urandom_range(0, 7) == 0) tgt = $urandom_range(1, tgt - 1);
    if (tgt == 0) tgt = 1;
    next_start = 1'b1;
    pos = 0;
    while (pos < tgt) begin
      if ($urandom_range(0, 99) < 7) begin
        // Broken or random header bytes; the region's stimulus ends here.
        case ($urandom_range(0, 3))
          0: push_byte(8'h00);
          1: push_byte(8'($urandom_range(1, 15)));
          2: begin
            push_byte(8'h80 | 8'($urandom));
            push_byte(8'h00);
          end
          default: push_byte(8'($urandom));
        endcase
        break;
      end
      add_element(hdr_bytes, payload);
      pos += hdr_bytes;
      for (int k = 0; k < payload && pos < tgt; k++) begin
        push_byte(8'($urandom));
        pos++;
      end
    end
    // One to three trailing bytes; the walk ignores them only where they lie past the region.
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
  endtask

  task automatic run_phase(input logic [31:0] len, input logic [31:0] base, input int tx,
                           input int rx, input int n, input bit hold, input bit pause_mid);
    int first;
    write_regions(len, base);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    first = bytes_queued;
    if (pause_mid) begin
      while (bytes_queued - first < n / 2) add_region(len);
      wait_drained();
    end
    while (bytes_queued - first < n) add_region(len);
    if (hold) hold_wanted = ~hold_wanted;
  endtask

  initial begin
    logic [31:0] rand_len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: first region without a start flag, offsets wrapping past the top,
    // smallest four-byte ID, unknown size, zero and over-long fields.
    write_regions(32'd16, 32'hFFFF_FFFC);
    push_bytes(1'b0, 3, 96'h80_81_AA);
    push_bytes(1'b0, 12, 96'h10_00_00_00_01_FF_FF_FF_FF_FF_FF_FF);
    push_bytes(1'b1, 1, 96'h00);
    push_bytes(1'b1, 1, 96'h0F);
    push_bytes(1'b1, 2, 96'h81_00);
    // Tiny region: size clamped to nothing, header cut off, too few bytes left.
    write_regions(32'd3, 32'd0);
    push_bytes(1'b1, 3, 96'h40_01_FF);
    push_bytes(1'b1, 3, 96'h1F_00_00);
    push_bytes(1'b1, 4, 96'h81_80_90_EE);

    // Random regions over several register settings and idling patterns.
    run_phase(32'd64, 32'd0, 0, 0, 250, 1'b0, 1'b0);
    run_phase(32'd200, $urandom, 47, 0, 250, 1'b0, 1'b0);
    run_phase(32'd40, 32'hFFFF_FFE0, 0, 47, 250, 1'b1, 1'b0);
    run_phase(32'd1, $urandom, 14, 14, 30, 1'b0, 1'b0);
    run_phase(32'd0, 32'hFFFF_FFFF, 0, 0, 20, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 14, 14, 250, 1'b0, 1'b0);
    run_phase(32'd2, 32'd0, 0, 47, 40, 1'b0, 1'b0);
    rand_len = $urandom_range(8, 300);
    run_phase(rand_len, $urandom, 14, 14, 300, 1'b0, 1'b1);
    run_phase(32'd24, 32'd0, 0, 0, 100, 1'b0, 1'b0);

    wait_drained();
    if (mismatches == 0 && expected_headers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
